/* hdl/cspar_pkg.sv */
// Command string parser package: character codes, phase encoding and result word type.
// No dependencies. Used by the channel interfaces and the parser top level.
package cspar_pkg;

    // Field widths fixed by the message format
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CMD_W   = 8;
    localparam int unsigned IDX_W   = 4;
    localparam int unsigned VALUE_W = 16;

    // Characters the parser reacts to
    localparam logic [BYTE_W-1:0] CHAR_F     = 8'h46;  // 'F' command start
    localparam logic [BYTE_W-1:0] CHAR_E     = 8'h45;  // 'E' message end
    localparam logic [BYTE_W-1:0] CHAR_CLOSE = 8'h29;  // ')'
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;  // '0'

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_SEEK  = 6'b000001,
        PH_DIG1  = 6'b000010,
        PH_DIG2  = 6'b000100,
        PH_OPEN  = 6'b001000,
        PH_PARAM = 6'b010000,
        PH_DONE  = 6'b100000
    } phase_t;

    // One result word
    typedef struct packed {
        logic [CMD_W-1:0]   command_number;
        logic [IDX_W-1:0]   param_index;
        logic [VALUE_W-1:0] param_value;
        logic               value_valid;
        logic               last_of_command;
        logic               message_end;
        logic               overflow;
    } result_t;

endpackage

/* hdl/cspar_in_if.sv */
// Input channel of the command string parser: one message byte per word.
// Depends on cspar_pkg for field widths.
interface cspar_in_if;
    logic                       valid;
    logic                       ready;
    logic [cspar_pkg::BYTE_W-1:0] byte_in;
    logic                       start_of_message;
    logic                       last_byte;

    modport source (output valid, output byte_in, output start_of_message,
                    output last_byte, input ready);
    modport sink   (input valid, input byte_in, input start_of_message,
                    input last_byte, output ready);
endinterface

/* hdl/cspar_out_if.sv */
// Output channel of the command string parser: one parameter report per word.
// Depends on cspar_pkg for field widths.
interface cspar_out_if;
    logic                          valid;
    logic                          ready;
    logic [cspar_pkg::CMD_W-1:0]   command_number;
    logic [cspar_pkg::IDX_W-1:0]   param_index;
    logic [cspar_pkg::VALUE_W-1:0] param_value;
    logic                          value_valid;
    logic                          last_of_command;
    logic                          message_end;
    logic                          overflow;

    modport source (output valid, output command_number, output param_index,
                    output param_value, output value_valid, output last_of_command,
                    output message_end, output overflow, input ready);
    modport sink   (input valid, input command_number, input param_index,
                    input param_value, input value_valid, input last_of_command,
                    input message_end, input overflow, output ready);
endinterface

/* hdl/command_string_parser_top.sv */
// Command string parser top level: byte-wide state machine with a registered result word.
// Depends on cspar_pkg, cspar_in_if and cspar_out_if.
//
// The parser takes one message byte per clock cycle and gives at most one result word
// per byte, in the cycle after taking it. The per-byte work is a single update of
// the phase, command number, accumulator and parameter count, which feeds the output
// register directly, so a byte can be taken every cycle whenever the output register is
// empty or being drained in the same cycle. A byte with start_of_message set restarts
// the search for 'F'. After 'E' or a byte flagged last_byte, bytes are taken but
// produce nothing until the next start_of_message. Parameters past MAX_PARAMS are
// reported at index MAX_PARAMS-1 with overflow set.
module command_string_parser_top #(
    parameter int unsigned MAX_PARAMS = 10
) (
    input  logic         clk,
    input  logic         rst_n,
    cspar_in_if.sink     in_ch,
    cspar_out_if.source  out_ch
);
    import cspar_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PARAMS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_PARAMS);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PARAMS - 1);

    phase_t             phase_reg, phase_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               out_valid_reg, out_valid_next;
    result_t            res_reg, res_next;

    phase_t             cur_phase;
    logic [CMD_W-1:0]   cur_cmd;
    logic [VALUE_W-1:0] cur_acc;
    logic [CNT_W-1:0]   cur_cnt;
    logic [BYTE_W-1:0]  digit;
    logic [VALUE_W-1:0] acc_times10;
    logic [IDX_W-1:0]   param_idx;
    logic               param_ovf;
    logic               emit;
    logic               accept;

    // Take a byte when the result register is empty or drains this cycle
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    // Start of message restarts the parser before the byte is handled
    always_comb
    begin
        if (in_ch.start_of_message)
        begin
            cur_phase = PH_SEEK;
            cur_cmd   = '0;
            cur_acc   = '0;
            cur_cnt   = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_cmd   = cmd_reg;
            cur_acc   = acc_reg;
            cur_cnt   = cnt_reg;
        end
    end

    // Digit value and wrapping multiply-by-ten as shifts
    assign digit       = in_ch.byte_in - CHAR_ZERO;
    assign acc_times10 = {cur_acc[VALUE_W-4:0], 3'b000} + {cur_acc[VALUE_W-2:0], 1'b0};

    // Saturate the reported index
    assign param_ovf = (cur_cnt >= CNT_MAX);
    assign param_idx = param_ovf ? IDX_LAST : IDX_W'(cur_cnt);

    // Per-byte state update and result
    always_comb
    begin
        phase_next = cur_phase;
        cmd_next   = cur_cmd;
        acc_next   = cur_acc;
        cnt_next   = cur_cnt;
        emit       = 1'b0;
        res_next   = '0;

        if (cur_phase == PH_DONE)
        begin
            // Hold until the next message starts
        end
        else if (in_ch.byte_in == CHAR_E)
        begin
            phase_next           = PH_DONE;
            emit                 = 1'b1;
            res_next.message_end = 1'b1;
        end
        else
        begin
            unique case (cur_phase)
                PH_SEEK:
                begin
                    if (in_ch.byte_in == CHAR_F)
                        phase_next = PH_DIG1;
                end
                PH_DIG1:
                begin
                    cmd_next   = {digit[CMD_W-4:0], 3'b000} + {digit[CMD_W-2:0], 1'b0};
                    phase_next = PH_DIG2;
                end
                PH_DIG2:
                begin
                    cmd_next   = cur_cmd + digit;
                    phase_next = PH_OPEN;
                end
                PH_OPEN:
                begin
                    acc_next = '0;
                    cnt_next = '0;
                    if (in_ch.byte_in == CHAR_CLOSE)
                    begin
                        emit                     = 1'b1;
                        res_next.command_number  = cur_cmd;
                        res_next.last_of_command = 1'b1;
                        phase_next               = PH_SEEK;
                    end
                    else
                        phase_next = PH_PARAM;
                end
                PH_PARAM:
                begin
                    if (in_ch.byte_in == CHAR_COMMA || in_ch.byte_in == CHAR_CLOSE)
                    begin
                        emit                    = 1'b1;
                        res_next.command_number = cur_cmd;
                        res_next.param_index    = param_idx;
                        res_next.param_value    = cur_acc;
                        res_next.value_valid    = 1'b1;
                        res_next.overflow       = param_ovf;
                        acc_next                = '0;
                        if (in_ch.byte_in == CHAR_CLOSE)
                        begin
                            res_next.last_of_command = 1'b1;
                            cnt_next                 = '0;
                            phase_next               = PH_SEEK;
                        end
                        else if (!param_ovf)
                            cnt_next = cur_cnt + 1'b1;
                    end
                    else
                        acc_next = acc_times10 + {{(VALUE_W-BYTE_W){1'b0}}, in_ch.byte_in}
                                   - VALUE_W'(CHAR_ZERO);
                end
                default:
                    phase_next = PH_SEEK;
            endcase

            // Last byte of the buffer closes the message
            if (in_ch.last_byte)
            begin
                if (!emit)
                    res_next = '0;
                res_next.message_end = 1'b1;
                emit                 = 1'b1;
                phase_next           = PH_DONE;
            end
        end
    end

    // Result register handshake
    always_comb
    begin
        if (accept)
            out_valid_next = emit;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SEEK;
            cmd_reg       <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                phase_reg <= phase_next;
                cmd_reg   <= cmd_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.command_number  = res_reg.command_number;
    assign out_ch.param_index     = res_reg.param_index;
    assign out_ch.param_value     = res_reg.param_value;
    assign out_ch.value_valid     = res_reg.value_valid;
    assign out_ch.last_of_command = res_reg.last_of_command;
    assign out_ch.message_end     = res_reg.message_end;
    assign out_ch.overflow        = res_reg.overflow;

endmodule
